>>> rtl/rcic_pkg.sv
`timescale 1ns / 1ps

package rcic_pkg;

  // Table size default; the top level hands it down as a parameter.
  localparam int unsigned ENTRIES_DEF = 64;

  // Identifier value of a free entry, and the saturation point of a count.
  localparam logic [15:0] ID_INVALID = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  // Request kinds.
  typedef enum logic [1:0] {
    MODE_GET  = 2'd0,
    MODE_DUP  = 2'd1,
    MODE_PUT  = 2'd2,
    MODE_NONE = 2'd3
  } rcic_mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_RANGE = 3'd2,
    ST_ZERO  = 3'd3,
    ST_OVF   = 3'd4
  } rcic_status_e;

  // Operation of the shared count unit.
  typedef enum logic {
    OP_INC = 1'b0,
    OP_DEC = 1'b1
  } rcic_op_e;

  // One request beat.
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] inode_number;
    logic [5:0]  slot;
    logic        no_links;
  } rcic_in_t;

  // One result beat.
  typedef struct packed {
    logic [5:0]  entry;
    logic        hit;
    logic [15:0] ref_after;
    logic        delete_needed;
    logic [2:0]  status;
  } rcic_out_t;

  // One table word.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] cnt;
  } rcic_word_t;

  // Verdict of the shared unit on one table word.
  typedef struct packed {
    logic         match;
    logic         free;
    logic         wr;
    logic [15:0]  cnt_next;
    logic         del;
    rcic_status_e status;
  } rcic_eval_t;

endpackage

>>> rtl/refcounted_inode_cache.sv
`timescale 1ns / 1ps

// Reference-counted identifier cache with ENTRIES table entries.
// Requests arrive on in_valid_i/in_ready_o as one beat each (get, dup, put);
// every request gives exactly one result beat on out_valid_o/out_ready_i.
// The identifier limit is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, as the block itself does not enforce this.
// After reset the block sweeps the table once to free every entry, and
// in_ready_o stays low during that sweep. A get scans the table one entry
// per cycle through the shared count unit: it stops at the first matching
// entry, otherwise it reads all ENTRIES entries. A get with an identifier
// at or above the limit, an unused mode, and a dup or put on a slot beyond
// the table give a result with no table access. A dup or put does one
// read-modify-write of the addressed entry.
// One request is worked on at a time; the next is accepted once the current
// result has moved into the output register. If the receiver stalls, the
// result is held there, one more request may be worked, and its result then
// waits until the output register frees up.
module refcounted_inode_cache #(
  parameter int unsigned ENTRIES = rcic_pkg::ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rcic_pkg::rcic_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rcic_pkg::rcic_out_t out_data_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] Last = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        ra_q, ra_d;
  logic                 rv_q, rv_d;
  logic [AW-1:0]        ri_q, ri_d;
  logic                 have_free_q, have_free_d;
  logic [AW-1:0]        free_idx_q, free_idx_d;
  rcic_pkg::rcic_in_t   req_q, req_d;
  rcic_pkg::rcic_out_t  res_q, res_d;
  rcic_pkg::rcic_out_t  out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [15:0]          limit_q;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  rcic_pkg::rcic_word_t mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  rcic_pkg::rcic_word_t mem_rdata;

  rcic_pkg::rcic_op_e   unit_op;
  rcic_pkg::rcic_eval_t ev;

  logic                 in_fire;
  logic                 can_emit;
  logic [AW+5:0]        in_slot_ext;
  logic [AW+5:0]        req_slot_ext;
  logic                 in_slot_ok;
  logic                 found;
  logic [AW-1:0]        fidx;

  // Low six bits of an entry index.
  function automatic logic [5:0] to_entry(input logic [AW-1:0] idx);
    logic [AW+5:0] ext;
    ext = (AW + 6)'(idx);
    return ext[5:0];
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign can_emit    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Slot addressing works for tables narrower and wider than the slot field.
  assign in_slot_ext  = (AW + 6)'(in_data_i.slot);
  assign req_slot_ext = (AW + 6)'(req_q.slot);
  assign in_slot_ok   = (32'(in_data_i.slot) < 32'(ENTRIES));

  // Free-entry choice at the end of a missed scan.
  assign found = have_free_q || ev.free;
  assign fidx  = have_free_q ? free_idx_q : ri_q;

  // The shared unit increments during a scan and for dup, decrements for put.
  assign unit_op = ((state_q == S_SCAN) || (req_q.mode == rcic_pkg::MODE_DUP)) ?
                   rcic_pkg::OP_INC : rcic_pkg::OP_DEC;

  rcic_table #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  rcic_unit u_unit (
    .op_i      (unit_op),
    .word_i    (mem_rdata),
    .key_i     (req_q.inode_number),
    .no_links_i(req_q.no_links),
    .res_o     (ev)
  );

  // Sequencer next state, table access and result assembly.
  always_comb begin
    state_d     = state_q;
    ra_d        = ra_q;
    rv_d        = rv_q;
    ri_d        = ri_q;
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = ra_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = ra_q;

    case (state_q)
      S_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = ra_q;
        mem_wdata.id   = rcic_pkg::ID_INVALID;
        mem_wdata.cnt  = 16'd0;
        if (ra_q == Last) begin
          ra_d    = '0;
          state_d = S_IDLE;
        end else begin
          ra_d = ra_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          req_d = in_data_i;
          res_d = '0;
          case (in_data_i.mode)
            rcic_pkg::MODE_GET: begin
              if (in_data_i.inode_number >= limit_q) begin
                res_d.status = rcic_pkg::ST_RANGE;
                state_d      = S_EMIT;
              end else begin
                ra_d        = '0;
                rv_d        = 1'b0;
                have_free_d = 1'b0;
                state_d     = S_SCAN;
              end
            end
            rcic_pkg::MODE_DUP, rcic_pkg::MODE_PUT: begin
              if (!in_slot_ok) begin
                res_d.entry  = in_data_i.slot;
                res_d.status = rcic_pkg::ST_ZERO;
                state_d      = S_EMIT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_slot_ext[AW-1:0];
                state_d   = S_RMW;
              end
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous word is evaluated.
        mem_re    = 1'b1;
        mem_raddr = ra_q;
        rv_d      = 1'b1;
        ri_d      = ra_q;
        if (ra_q != Last) begin
          ra_d = ra_q + AW'(1);
        end
        if (rv_q) begin
          if (ev.match) begin
            mem_we          = ev.wr;
            mem_waddr       = ri_q;
            mem_wdata.id    = mem_rdata.id;
            mem_wdata.cnt   = ev.cnt_next;
            res_d           = '0;
            res_d.entry     = to_entry(ri_q);
            res_d.hit       = 1'b1;
            res_d.ref_after = ev.cnt_next;
            res_d.status    = ev.status;
            state_d         = S_EMIT;
          end else begin
            if (ev.free && !have_free_q) begin
              have_free_d = 1'b1;
              free_idx_d  = ri_q;
            end
            if (ri_q == Last) begin
              res_d = '0;
              if (found) begin
                mem_we          = 1'b1;
                mem_waddr       = fidx;
                mem_wdata.id    = req_q.inode_number;
                mem_wdata.cnt   = 16'd1;
                res_d.entry     = to_entry(fidx);
                res_d.ref_after = 16'd1;
                res_d.status    = rcic_pkg::ST_OK;
              end else begin
                res_d.status = rcic_pkg::ST_FULL;
              end
              state_d = S_EMIT;
            end
          end
        end
      end

      S_RMW: begin
        // Dup or put on the word read in the previous cycle.
        mem_we          = ev.wr;
        mem_waddr       = req_slot_ext[AW-1:0];
        mem_wdata.id    = (ev.cnt_next == 16'd0) ? rcic_pkg::ID_INVALID : mem_rdata.id;
        mem_wdata.cnt   = ev.cnt_next;
        res_d           = '0;
        res_d.entry     = req_q.slot;
        res_d.ref_after = ev.cnt_next;
        res_d.delete_needed = ev.del;
        res_d.status    = ev.status;
        state_d         = S_EMIT;
      end

      S_EMIT: begin
        if (can_emit) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
        ra_d    = '0;
      end
    endcase
  end

  // Sequencer state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ra_q        <= '0;
      rv_q        <= 1'b0;
      have_free_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ra_q        <= ra_d;
      rv_q        <= rv_d;
      have_free_q <= have_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ri_q       <= ri_d;
    free_idx_q <= free_idx_d;
    req_q      <= req_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // Identifier limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= rcic_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

`ifndef SYNTHESIS
  // The table is never written while a result waits to be emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !mem_we)
    else $error("table written during result hand-off");

  // A read-modify-write is always followed by the emit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RMW) |=> (state_q == S_EMIT))
    else $error("read-modify-write did not complete");

  // A scan only evaluates entries inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && rv_q) |-> (ri_q <= Last))
    else $error("scan index beyond table");

  // A hit only reports success or saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit) |->
      ((out_q.status == rcic_pkg::ST_OK) || (out_q.status == rcic_pkg::ST_OVF)))
    else $error("hit with unexpected status");

  // A new result is loaded only when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && out_valid_q && !out_ready_i) |=> (state_q == S_EMIT))
    else $error("result loaded over a stalled beat");
`endif

endmodule

>>> rtl/rcic_table.sv
`timescale 1ns / 1ps

module rcic_table #(
  parameter int unsigned ENTRIES = rcic_pkg::ENTRIES_DEF,
  parameter int unsigned AW = $clog2(ENTRIES)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  rcic_pkg::rcic_word_t wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output rcic_pkg::rcic_word_t rdata_o
);

  rcic_pkg::rcic_word_t mem [ENTRIES];
  rcic_pkg::rcic_word_t rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rcic_unit.sv
`timescale 1ns / 1ps

module rcic_unit (
  input  rcic_pkg::rcic_op_e   op_i,
  input  rcic_pkg::rcic_word_t word_i,
  input  logic [15:0]          key_i,
  input  logic                 no_links_i,
  output rcic_pkg::rcic_eval_t res_o
);

  logic cnt_zero;

  assign cnt_zero = (word_i.cnt == 16'd0);

  // Compare one word against the key and work out its updated count.
  always_comb begin
    res_o          = '0;
    res_o.match    = !cnt_zero && (word_i.id == key_i);
    res_o.free     = cnt_zero;
    res_o.cnt_next = word_i.cnt;
    res_o.status   = rcic_pkg::ST_OK;
    if (cnt_zero) begin
      res_o.status = rcic_pkg::ST_ZERO;
    end else if (op_i == rcic_pkg::OP_INC) begin
      if (word_i.cnt == rcic_pkg::COUNT_MAX) begin
        res_o.status = rcic_pkg::ST_OVF;
      end else begin
        res_o.cnt_next = word_i.cnt + 16'd1;
        res_o.wr       = 1'b1;
      end
    end else begin
      res_o.cnt_next = word_i.cnt - 16'd1;
      res_o.wr       = 1'b1;
      res_o.del      = (word_i.cnt == 16'd1) && no_links_i;
    end
  end

endmodule
